// ----- sv/bb3_pkg.sv -----
// Shared types, constants and the divide-by-count reciprocal table for the 3x3 box blur.
// No dependencies; used by bb3_ctrl, bb3_dp and box_blur_3x3_rgb.
package bb3_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int CFG_W_WIDTH        = 11;
    localparam int CFG_H_WIDTH        = 16;
    localparam int RECIP_SHIFT        = 18;
    localparam int RECIP_WIDTH        = 18;
    localparam int SUM_WIDTH          = 12;
    localparam int CNT_WIDTH          = 4;
    localparam int NUM_WIDTH          = 13;

    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W_WIDTH-1:0] LINE_WIDTH_RST   = 11'd640;
    localparam logic [CFG_H_WIDTH-1:0] FRAME_HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic load;
        logic rd;
        logic shift;
        logic sum;
        logic mul;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic emit;
    } status_t;

    // ceil(2^18 / (2*n)); exact floor quotient for numerators below 4600
    function automatic logic [RECIP_WIDTH-1:0] recip(input logic [CNT_WIDTH-1:0] n);
        logic [RECIP_WIDTH-1:0] m;
        case (n)
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

// ----- sv/bb3_ctrl.sv -----
// Sequencer for the box blur: handshakes and per-transfer command pulses.
// Depends on bb3_pkg (cmd_t, status_t).
module bb3_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bb3_pkg::status_t status,
    output bb3_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_SUM   = 6'b001000,
        S_MUL   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // an early drain tick is dropped without touching state
                if (in_valid && !status.ignore)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = status.emit ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- sv/bb3_dp.sv -----
// Datapath for the box blur: line stores, 3x3 window, position counters, sum and divide.
// Depends on bb3_pkg; driven by bb3_ctrl commands.
module bb3_dp #(
    parameter int MAX_LINE_WIDTH = bb3_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bb3_pkg::CFG_W_WIDTH-1:0] line_width,
    input  logic [bb3_pkg::CFG_H_WIDTH-1:0] frame_height,
    input  logic                            cfg_clear,
    input  logic                            mode,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    input  bb3_pkg::cmd_t                   cmd,
    output bb3_pkg::status_t                status,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    output logic                            frame_last
);

    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int LW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int HW = bb3_pkg::CFG_H_WIDTH;
    localparam int SW = bb3_pkg::SUM_WIDTH;
    localparam int CW = bb3_pkg::CNT_WIDTH;
    localparam int NW = bb3_pkg::NUM_WIDTH;
    localparam int RW = bb3_pkg::RECIP_WIDTH;
    localparam int RS = bb3_pkg::RECIP_SHIFT;

    logic [23:0]   upper_line_reg [MAX_LINE_WIDTH];
    logic [23:0]   middle_line_reg [MAX_LINE_WIDTH];
    logic [23:0]   top_rd_reg, mid_rd_reg;
    logic [23:0]   pix_reg;
    logic [23:0]   win_reg [3][3];
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [HW:0]   in_row_reg, in_row_next;
    logic [AW-1:0] oc_col_reg;
    logic [HW-1:0] oc_row_reg;
    logic          emit_reg;
    logic [SW-1:0] sum_reg [3];
    logic [CW-1:0] cnt_reg;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic          last_reg;

    logic [LW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          in_done, in_wrap, primed;
    logic          oc_wrap, oc_lastrow, last;
    logic [2:0]    row_use, col_use;
    logic [SW-1:0] sum_c [3];
    logic [CW-1:0] cnt_c;
    logic [NW-1:0] num [3];
    logic [NW+RW-1:0] prod [3];

    always_comb
    begin
        if (line_width == '0)
            eff_w = LW'(1);
        else if (32'(line_width) > MAX_LINE_WIDTH)
            eff_w = LW'(MAX_LINE_WIDTH);
        else
            eff_w = LW'(line_width);
        eff_h = (frame_height == '0) ? HW'(1) : frame_height;
    end

    assign in_done     = (in_row_reg >= {1'b0, eff_h});
    assign in_wrap     = (LW'({1'b0, in_col_reg}) + LW'(1) == eff_w);
    assign in_col_next = in_wrap ? '0 : in_col_reg + AW'(1);
    assign in_row_next = in_wrap ? in_row_reg + (HW+1)'(1) : in_row_reg;
    // position n >= width+1
    assign primed      = (in_row_reg >= (HW+1)'(2)) ||
                         ((in_row_reg == (HW+1)'(1)) && (in_col_reg != '0));

    assign status.ignore = mode && !in_done;
    assign status.emit   = primed;

    assign oc_wrap    = (LW'({1'b0, oc_col_reg}) + LW'(1) == eff_w);
    assign oc_lastrow = (oc_row_reg == eff_h - HW'(1));
    assign last       = oc_wrap && oc_lastrow;
    assign row_use    = {!oc_lastrow, 1'b1, oc_row_reg != '0};
    assign col_use    = {!oc_wrap, 1'b1, oc_col_reg != '0};

    always_comb
    begin
        logic [1:0] nr, nc;
        for (int c = 0; c < 3; c++)
        begin
            sum_c[c] = '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (row_use[i] && col_use[j])
                        sum_c[c] = sum_c[c] + SW'(win_reg[i][j][23-8*c -: 8]);
        end
        nr    = 2'(row_use[0]) + 2'(row_use[1]) + 2'(row_use[2]);
        nc    = 2'(col_use[0]) + 2'(col_use[1]) + 2'(col_use[2]);
        cnt_c = CW'(nr) * CW'(nc);
        for (int c = 0; c < 3; c++)
        begin
            // round half up: (2*sum + n) / (2*n)
            num[c]  = {sum_reg[c], 1'b0} + NW'(cnt_reg);
            prod[c] = (NW+RW)'(num[c]) * (NW+RW)'(bb3_pkg::recip(cnt_reg));
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            top_rd_reg <= upper_line_reg[in_col_reg];
            mid_rd_reg <= middle_line_reg[in_col_reg];
        end
        if (cmd.shift)
        begin
            upper_line_reg[in_col_reg]  <= mid_rd_reg;
            middle_line_reg[in_col_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= in_done ? 24'd0 : {red_in, green_in, blue_in};
        if (cmd.sum)
        begin
            for (int c = 0; c < 3; c++)
                sum_reg[c] <= sum_c[c];
            cnt_reg <= cnt_c;
        end
        if (cmd.mul)
        begin
            red_reg   <= prod[0][RS +: 8];
            green_reg <= prod[1][RS +: 8];
            blue_reg  <= prod[2][RS +: 8];
            last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
            oc_col_reg <= '0;
            oc_row_reg <= '0;
            emit_reg   <= 1'b0;
        end
        else if (cfg_clear)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            oc_col_reg <= '0;
            oc_row_reg <= '0;
        end
        else
        begin
            if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_rd_reg;
                win_reg[1][2] <= mid_rd_reg;
                win_reg[2][2] <= pix_reg;
                in_col_reg    <= in_col_next;
                in_row_reg    <= in_row_next;
                emit_reg      <= primed;
            end
            if (cmd.mul)
            begin
                if (last)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                    oc_col_reg <= '0;
                    oc_row_reg <= '0;
                end
                else if (oc_wrap)
                begin
                    oc_col_reg <= '0;
                    oc_row_reg <= oc_row_reg + HW'(1);
                end
                else
                    oc_col_reg <= oc_col_reg + AW'(1);
            end
        end
    end

    assign red_out    = red_reg;
    assign green_out  = green_reg;
    assign blue_out   = blue_reg;
    assign frame_last = last_reg & emit_reg;

endmodule

// ----- sv/box_blur_3x3_rgb.sv -----
// 3x3 RGB box blur, top level: APB register block plus controller and datapath.
// Each transfer steps through read and shift, then, when a result is due, sum, multiply and output
// (waiting for out_ready); an early drain ends in idle. A new input is taken only in idle.
// A result appears for the pixel width+1 positions behind the newest input.
// rst_n is asynchronous: counters and window clear, registers go to 640 x 480.
// Line stores are not cleared; unwritten entries only feed rows above the frame.
module box_blur_3x3_rgb #(
    parameter int MAX_LINE_WIDTH = bb3_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic        frame_last
);

    logic [bb3_pkg::CFG_W_WIDTH-1:0] line_width_reg;
    logic [bb3_pkg::CFG_H_WIDTH-1:0] frame_height_reg;
    logic                            cfg_wr;
    bb3_pkg::cmd_t                   cmd;
    bb3_pkg::status_t                status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= bb3_pkg::LINE_WIDTH_RST;
            frame_height_reg <= bb3_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bb3_pkg::REG_LINE_WIDTH:
                    line_width_reg <= pwdata[bb3_pkg::CFG_W_WIDTH-1:0];
                bb3_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= pwdata[bb3_pkg::CFG_H_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bb3_pkg::REG_LINE_WIDTH:   prdata = 32'(line_width_reg);
            bb3_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    bb3_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bb3_dp #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .line_width   (line_width_reg),
        .frame_height (frame_height_reg),
        .cfg_clear    (cfg_wr),
        .mode         (mode),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .cmd          (cmd),
        .status       (status),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .frame_last   (frame_last)
    );

endmodule

// ----- tb/bb3_checker.sv -----
// Checker for box_blur_3x3_rgb: watches the APB port and both streams, predicts each
// blurred pixel and compares it with the block's output. Depends on nothing but the ports.
module bb3_checker #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  red_out,
    input  logic [7:0]  green_out,
    input  logic [7:0]  blue_out,
    input  logic        frame_last,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } blur_px_t;

    blur_px_t    blur_q[$];
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] upper_row[MAX_LINE_WIDTH];
    logic [23:0] middle_row[MAX_LINE_WIDTH];
    logic [23:0] win[3][3];
    int unsigned pix_taken;
    int unsigned px_next;

    assign pending = blur_q.size();

    function automatic logic [7:0] round_avg(int unsigned sum, int unsigned n);
        return 8'((2 * sum + n) / (2 * n));
    endfunction

    task automatic blur_step(logic md, logic [23:0] pix_in);
        int unsigned w, h, total, n, col, q, rq, cq, sr, sg, sb, cnt;
        logic [23:0] top, mid, pix, v;
        blur_px_t    px;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        total = w * h;
        pix = '0;
        if (pix_taken < total)
        begin
            if (md) return;     // early drain is ignored
            pix = pix_in;
        end
        n = pix_taken;
        col = n % w;
        top = upper_row[col];
        mid = middle_row[col];
        upper_row[col] = mid;
        middle_row[col] = pix;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        pix_taken = n + 1;
        if (n < w + 1) return;
        q = px_next;
        rq = q / w;
        cq = q % w;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!((i == 0 && rq == 0) || (i == 2 && rq + 1 >= h) ||
                      (j == 0 && cq == 0) || (j == 2 && cq + 1 >= w)))
                begin
                    v = win[i][j];
                    sr += v[23:16];
                    sg += v[15:8];
                    sb += v[7:0];
                    cnt++;
                end
            end
        end
        px.r = round_avg(sr, cnt);
        px.g = round_avg(sg, cnt);
        px.b = round_avg(sb, cnt);
        px.last = (q + 1 >= total);
        blur_q.push_back(px);
        if (px.last)
        begin
            pix_taken = 0;
            px_next = 0;
        end
        else
        begin
            px_next = q + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blur_px_t exp_px;
        if (!rst_n)
        begin
            width_reg = 11'd640;
            height_reg = 16'd480;
            pix_taken = 0;
            px_next = 0;
            errors = 0;
            blur_q.delete();
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            for (int k = 0; k < MAX_LINE_WIDTH; k++)
            begin
                upper_row[k] = '0;
                middle_row[k] = '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                // register index is paddr/4; only indexes 0 and 1 exist
                if (paddr[2] == 1'b0)
                    width_reg = pwdata[10:0];
                else
                    height_reg = pwdata[15:0];
                pix_taken = 0;
                px_next = 0;
            end
            if (out_valid && out_ready)
            begin
                if (blur_q.size() == 0)
                begin
                    $display("%0t: unexpected output transfer %h %h %h last=%b", $time,
                             red_out, green_out, blue_out, frame_last);
                    errors++;
                end
                else
                begin
                    exp_px = blur_q.pop_front();
                    if (exp_px.r !== red_out || exp_px.g !== green_out ||
                        exp_px.b !== blue_out || exp_px.last !== frame_last)
                    begin
                        $display("%0t: mismatch expected %h %h %h last=%b got %h %h %h last=%b",
                                 $time, exp_px.r, exp_px.g, exp_px.b, exp_px.last,
                                 red_out, green_out, blue_out, frame_last);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                blur_step(mode, {red_in, green_in, blue_in});
        end
    end

endmodule

// ----- tb/tb_box_blur_3x3_rgb.sv -----
// Testbench top for box_blur_3x3_rgb: clock, reset, APB writes and pixel stimulus.
// Depends on bb3_pkg, the block and bb3_checker, which does the prediction.
module tb_box_blur_3x3_rgb;

    localparam int IDLE_WAIT = 20;
    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        in_valid, in_ready, mode;
    logic [7:0]  red_in, green_in, blue_in;
    logic        out_valid, out_ready;
    logic [7:0]  red_out, green_out, blue_out;
    logic        frame_last;
    int          errors, pending;
    int          items_sent;
    int          stall_cycles;
    bit          calm;

    box_blur_3x3_rgb dut (.*);

    bb3_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= (idx == bb3_pkg::REG_FRAME_HEIGHT) ? 3'd4 : 3'd0;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // let every outstanding result drain and the block settle before a register write
    task automatic settle();
        wait (pending == 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic send(logic md, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(posedge clk);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
        items_sent++;
        calm = (items_sent > 300 && items_sent < 800);
    endtask

    function automatic logic [7:0] chan(int style);
        case (style)
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // one well-formed frame: pixels, with ignored early drains mixed in when noisy, then drains
    task automatic run_frame(int w, int h, int style, bit noisy);
        for (int k = 0; k < w * h; k++)
        begin
            if (noisy && $urandom_range(9) == 0)
                send(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
            send(1'b0, chan(style), chan(style), chan(style));
        end
        // pixel items past the frame end act as drains
        for (int k = 0; k <= w; k++)
            send(noisy ? 1'($urandom) : 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        if (noisy)
            repeat ($urandom_range(2)) send(1'b1, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic frame_cfg(int w_reg, int h_reg, int w, int h, int style, bit noisy);
        settle();
        reg_write(bb3_pkg::REG_LINE_WIDTH, 32'(w_reg));
        reg_write(bb3_pkg::REG_FRAME_HEIGHT, 32'(h_reg));
        run_frame(w, h, style, noisy);
    endtask

    initial
    begin
        int w, h;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        out_ready = 1'b0;
        stall_cycles = 0;
        items_sent = 0;
        calm = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of the registers and of the pixel values
        frame_cfg(1, 1, 1, 1, 1, 0);
        frame_cfg(0, 0, 1, 1, 0, 0);
        frame_cfg(3, 3, 3, 3, 1, 0);
        frame_cfg(3, 3, 3, 3, 0, 1);
        frame_cfg(2, 3, 2, 3, 2, 1);
        // height at maximum: run part of a frame, then abandon it by a write
        settle();
        reg_write(bb3_pkg::REG_LINE_WIDTH, 32'd1);
        reg_write(bb3_pkg::REG_FRAME_HEIGHT, 32'hffff);
        repeat (12) send(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        // width above the maximum acts as the maximum: go just past the first
        // results, then abandon the frame by the next write
        settle();
        reg_write(bb3_pkg::REG_LINE_WIDTH, 32'd2047);
        reg_write(bb3_pkg::REG_FRAME_HEIGHT, 32'd2);
        repeat (1030) send(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));

        while (items_sent < 1150)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            frame_cfg(w, h, w, h, ($urandom_range(9) == 0) ? $urandom_range(1) : 2, 1);
        end

        wait (pending == 0);
        repeat (IDLE_WAIT * 5) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
